FILE: rtl/core/life_generation_engine_macros.svh
// Assertion macros used by the checker of the cell grid engine.
// Every property is clocked on aclk and is switched off while aresetn is low.
`ifndef LIFE_GENERATION_ENGINE_MACROS_SVH
`define LIFE_GENERATION_ENGINE_MACROS_SVH

// The antecedent implies the consequent, checked on every clock edge.
`define LGE_ASSERT_IMPLIES(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// The expression must never be true on a clock edge.
`define LGE_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

FILE: rtl/core/lge_pkg.sv
`default_nettype none
package lge_pkg;

    // Command codes of an input beat.
    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_NONE    = 2'd3
    } lge_cmd_t;

    // Register indexes on the configuration port.
    localparam int unsigned REG_ROWS = 0;
    localparam int unsigned REG_COLS = 1;

    // B3/S23 neighbor counts.
    localparam logic [3:0] BORN_COUNT = 4'd3;
    localparam logic [3:0] KEEP_COUNT = 4'd2;

    // Smallest grid size that a register value is raised to.
    localparam int unsigned MIN_SIZE = 2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_LOAD_CUR,
        ST_LOAD_NXT,
        ST_CELL,
        ST_WRBACK,
        ST_DONE
    } lge_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/life_generation_engine.sv
`default_nettype none
// Cell grid engine for the B3/S23 rule (Conway's Game of Life). The block holds a grid of
// MAX_ROWS by MAX_COLS one-bit cells, of which the top-left rows_in_use by cols_in_use cells
// take part (register values below 2 act as 2, values above the maximum act as the maximum).
// Each input beat writes a cell, reads a cell, advances the active grid one generation, or
// does nothing; each beat returns exactly one result; cell_out carries the cell on a read
// and 0 otherwise, also for an address outside the active grid, whose write is dropped.
// Borders do not wrap and cells outside the active grid count as dead; cells beyond the
// active grid keep their values. The grid sits in a row-wide memory with one write port and
// one registered read port. A write or a read fetches its row through the read port, and a
// write then stores the row back with its one cell changed through the write port. On an
// advance a single neighbor-count and rule unit visits one cell per cycle out of three row
// buffers, and each row adds a write-back state and a load of the row below. After reset a
// clearing pass writes MAX_ROWS rows of dead cells, one row per cycle, and no input beat is
// taken until it is done; configuration writes are taken at all times. A finished result
// waits in an output register, and the next input beat is taken while it waits.
module life_generation_engine #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel.
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [5:0]  s_row,
    input  wire logic [5:0]  s_column,
    input  wire logic        s_cell_in,
    // Result channel.
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_cell_out,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import lge_pkg::*;

    // Index widths for the memory rows and the columns, and count widths for the sizes.
    localparam int RAW = $clog2(MAX_ROWS);
    localparam int CAW = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int CW  = $clog2(MAX_COLS + 1);

    // The grid, one memory word per row.
    logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] rd_data_reg;
    logic                mem_we;
    logic [RAW-1:0]      mem_waddr;
    logic [MAX_COLS-1:0] mem_wdata;
    logic [RAW-1:0]      mem_raddr;

    lge_state_t state_reg, state_next;

    logic [6:0]          rows_reg, cols_reg;
    logic [RAW-1:0]      r_reg, r_next;
    logic [CAW-1:0]      c_reg, c_next;
    lge_cmd_t            cmd_reg, cmd_next;
    logic                val_reg, val_next;
    logic                result_reg, result_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_cell_out_reg, m_cell_out_next;

    // Row buffers: old row above, old current row, old row below, and the new current row.
    logic [MAX_COLS-1:0] prev_reg, prev_next;
    logic [MAX_COLS-1:0] cur_reg, cur_next;
    logic [MAX_COLS-1:0] nxt_reg, nxt_next;
    logic [MAX_COLS-1:0] new_reg, new_next;

    logic [RW-1:0]       eff_rows;
    logic [CW-1:0]       eff_cols;
    logic                in_grid;
    logic                accept;
    logic                out_load;
    logic                last_col;
    logic                last_row;
    logic                below_valid;
    logic                clear_done;
    logic [CAW-1:0]      idx_l, idx_r;
    logic                lv, rv;
    logic [3:0]          nbr_count;
    logic                rule_bit;
    logic                cfg_write;

    // Effective grid size after clamping the register values.
    always_comb begin
        if (32'(rows_reg) < 32'(MIN_SIZE)) begin
            eff_rows = RW'(MIN_SIZE);
        end else if (32'(rows_reg) > 32'(MAX_ROWS)) begin
            eff_rows = RW'(MAX_ROWS);
        end else begin
            eff_rows = RW'(rows_reg);
        end
        if (32'(cols_reg) < 32'(MIN_SIZE)) begin
            eff_cols = CW'(MIN_SIZE);
        end else if (32'(cols_reg) > 32'(MAX_COLS)) begin
            eff_cols = CW'(MAX_COLS);
        end else begin
            eff_cols = CW'(cols_reg);
        end
    end

    assign in_grid  = (32'(s_row) < 32'(eff_rows)) && (32'(s_column) < 32'(eff_cols));
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign last_col    = (32'(c_reg) + 32'd1) == 32'(eff_cols);
    assign last_row    = (32'(r_reg) + 32'd1) == 32'(eff_rows);
    assign below_valid = (32'(r_reg) + 32'd1) < 32'(eff_rows);
    assign clear_done  = (32'(r_reg) + 32'd1) == 32'(MAX_ROWS);

    // Shared neighbor-count and rule unit for the cell at column c_reg. A neighbor to the
    // left of column 0 or to the right of the last active column counts as dead.
    assign idx_l = CAW'(c_reg - CAW'(1));
    assign idx_r = CAW'(c_reg + CAW'(1));
    assign lv    = (c_reg != '0);
    assign rv    = !last_col;

    always_comb begin
        nbr_count = 4'(prev_reg[idx_l] & lv) + 4'(prev_reg[c_reg]) + 4'(prev_reg[idx_r] & rv)
                  + 4'(cur_reg[idx_l] & lv)                          + 4'(cur_reg[idx_r] & rv)
                  + 4'(nxt_reg[idx_l] & lv)  + 4'(nxt_reg[c_reg])  + 4'(nxt_reg[idx_r] & rv);
        if (nbr_count == BORN_COUNT) begin
            rule_bit = 1'b1;
        end else if (nbr_count == KEEP_COUNT) begin
            rule_bit = cur_reg[c_reg];
        end else begin
            rule_bit = 1'b0;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_command == CMD_ADVANCE) begin
                        state_next = ST_LOAD_CUR;
                    end else if ((s_command == CMD_WRITE || s_command == CMD_READ) && in_grid) begin
                        state_next = ST_FETCH;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FETCH:    state_next = ST_DONE;
            ST_LOAD_CUR: state_next = ST_LOAD_NXT;
            ST_LOAD_NXT: state_next = ST_CELL;
            ST_CELL: begin
                if (last_col) begin
                    state_next = ST_WRBACK;
                end
            end
            ST_WRBACK: begin
                state_next = last_row ? ST_DONE : ST_LOAD_NXT;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        r_next          = r_reg;
        c_next          = c_reg;
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        result_next     = result_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        new_next        = new_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_cell_out_next = m_cell_out_reg;
        mem_we          = 1'b0;
        mem_waddr       = r_reg;
        mem_wdata       = new_reg;
        mem_raddr       = r_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                r_next    = RAW'(r_reg + RAW'(1));
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd_next    = lge_cmd_t'(s_command);
                    val_next    = s_cell_in;
                    result_next = 1'b0;
                    prev_next   = '0;
                    if (s_command == CMD_ADVANCE) begin
                        r_next    = '0;
                        mem_raddr = '0;
                    end else begin
                        r_next    = RAW'(s_row);
                        c_next    = CAW'(s_column);
                        mem_raddr = RAW'(s_row);
                    end
                end
            end
            ST_FETCH: begin
                if (cmd_reg == CMD_READ) begin
                    result_next = rd_data_reg[c_reg];
                end else begin
                    mem_we           = 1'b1;
                    mem_wdata        = rd_data_reg;
                    mem_wdata[c_reg] = val_reg;
                end
            end
            ST_LOAD_CUR: begin
                cur_next  = rd_data_reg;
                mem_raddr = RAW'(1);
            end
            ST_LOAD_NXT: begin
                nxt_next = below_valid ? rd_data_reg : '0;
                new_next = cur_reg;
                c_next   = '0;
            end
            ST_CELL: begin
                new_next[c_reg] = rule_bit;
                c_next          = CAW'(c_reg + CAW'(1));
            end
            ST_WRBACK: begin
                mem_we    = 1'b1;
                mem_wdata = new_reg;
                prev_next = cur_reg;
                cur_next  = nxt_reg;
                r_next    = RAW'(r_reg + RAW'(1));
                mem_raddr = RAW'(r_reg + RAW'(2));
            end
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next    = 1'b1;
                    m_cell_out_next = result_reg;
                end
            end
        endcase
    end

    // Row-wide grid memory with a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= grid_mem[mem_raddr];
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            r_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            r_reg       <= r_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        c_reg          <= c_next;
        cmd_reg        <= cmd_next;
        val_reg        <= val_next;
        result_reg     <= result_next;
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        nxt_reg        <= nxt_next;
        new_reg        <= new_next;
        m_cell_out_reg <= m_cell_out_next;
    end

    // Configuration registers. The word address in paddr[2] selects the register.
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= 7'd64;
            cols_reg <= 7'd64;
        end else if (cfg_write) begin
            if (32'(paddr[2]) == REG_ROWS) begin
                rows_reg <= pwdata[6:0];
            end
            if (32'(paddr[2]) == REG_COLS) begin
                cols_reg <= pwdata[6:0];
            end
        end
    end

    assign pready     = 1'b1;
    assign prdata     = (32'(paddr[2]) == REG_COLS) ? {25'd0, cols_reg} : {25'd0, rows_reg};
    assign m_valid    = m_valid_reg;
    assign m_cell_out = m_cell_out_reg;

endmodule
`default_nettype wire

FILE: rtl/core/lge_checker.sv
`default_nettype none
`include "life_generation_engine_macros.svh"
module lge_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic pready
);
    import lge_pkg::*;

    // A result waiting at the output stays until it is taken.
    `LGE_ASSERT_IMPLIES(a_out_hold, (m_valid && !m_ready) |=> m_valid, "result beat dropped")
    // Every accepted beat keeps the block busy for at least the following cycle.
    `LGE_ASSERT_IMPLIES(a_busy_after_accept, (s_valid && s_ready) |=> !s_ready,
                        "input taken while busy")
    // A new result only appears when the block was busy (s_ready low) on the previous clock edge.
    `LGE_ASSERT_IMPLIES(a_result_from_work, $rose(m_valid) |-> $past(!s_ready),
                        "result appeared without work")
    // The configuration port never inserts wait states.
    `LGE_ASSERT_NEVER(a_pready_high, !pready, "pready dropped")

endmodule

bind life_generation_engine lge_checker u_lge_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .pready  (pready)
);
`default_nettype wire

FILE: tb/tb_life_generation_engine.sv
`timescale 1ns / 100ps

module tb_life_generation_engine;

    import lge_pkg::*;

    // The grid is built at its default size; the checker keeps a grid of the same shape.
    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;

    // The run is declared a failure once it reaches this many cycles. The slowest correct run
    // (a handful of full 64 by 64 advances, random stalls on both channels and one long
    // receiver hold-off) stays far below it.
    localparam int CYCLE_LIMIT = 500000;

    // Length of the long receiver hold-off that fills the block and stalls its input.
    localparam int HOLD_CYCLES = 300;

    // One input beat as it waits in the send queue.
    typedef struct packed {
        lge_cmd_t   cmd;
        logic [5:0] row;
        logic [5:0] col;
        logic       cell_val;
    } life_beat_t;

    logic        aclk;
    logic        aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = CMD_NONE;
    logic [5:0]  s_row = '0;
    logic [5:0]  s_column = '0;
    logic        s_cell_in = 1'b0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_cell_out;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Beats waiting to be offered, and cell values still owed by the block, oldest first.
    life_beat_t  beat_queue[$];
    logic        expected_cell_out[$];
    life_beat_t  next_beat;

    // The checker's own copy of the grid and of the two size registers.
    bit          model_cells [GRID_ROWS][GRID_COLS];
    logic [6:0]  rows_reg = 7'd64;
    logic [6:0]  cols_reg = 7'd64;

    // Idling knobs, changed only between phases.
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // The long hold-off is requested by bumping hold_request; its own process counts it down.
    int          hold_request = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    int          cycle_count = 0;
    int          mismatch_count = 0;
    int          beats_accepted = 0;
    int          advances_done = 0;
    int          reads_done = 0;
    int          results_checked = 0;
    int          sizes_tried = 0;

    life_generation_engine #(
        .MAX_ROWS (GRID_ROWS),
        .MAX_COLS (GRID_COLS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_row      (s_row),
        .s_column   (s_column),
        .s_cell_in  (s_cell_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cell_out (m_cell_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // A register value below the minimum acts as the minimum, one above the grid as the grid.
    function automatic int effective_size(logic [6:0] value, int limit);
        if (int'(value) < int'(MIN_SIZE)) begin
            return int'(MIN_SIZE);
        end
        if (int'(value) > limit) begin
            return limit;
        end
        return int'(value);
    endfunction

    // One B3/S23 generation over the active grid. Every count is taken from the old
    // generation, borders do not wrap, and cells outside the active grid are neither
    // counted nor changed.
    function automatic void step_generation();
        bit old_cells [GRID_ROWS][GRID_COLS];
        int nr;
        int nc;
        int live;
        int rr;
        int cc;
        old_cells = model_cells;
        nr = effective_size(rows_reg, GRID_ROWS);
        nc = effective_size(cols_reg, GRID_COLS);
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                live = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc) begin
                            live += old_cells[rr][cc];
                        end
                    end
                end
                if (live == int'(BORN_COUNT)) begin
                    model_cells[r][c] = 1'b1;
                end else if (live == int'(KEEP_COUNT)) begin
                    model_cells[r][c] = old_cells[r][c];
                end else begin
                    model_cells[r][c] = 1'b0;
                end
            end
        end
    endfunction

    // Applies one accepted beat to the checker's grid and returns the cell value the block
    // must answer with. Writes and reads outside the active grid are dropped and answer 0.
    function automatic logic predict_cell_out(lge_cmd_t cmd, logic [5:0] row, logic [5:0] col,
                                              logic cell_val);
        int   nr;
        int   nc;
        logic inside_grid;
        logic result;
        nr = effective_size(rows_reg, GRID_ROWS);
        nc = effective_size(cols_reg, GRID_COLS);
        inside_grid = (int'(row) < nr) && (int'(col) < nc);
        result = 1'b0;
        case (cmd)
            CMD_WRITE: begin
                if (inside_grid) begin
                    model_cells[row][col] = cell_val;
                end
            end
            CMD_READ: begin
                if (inside_grid) begin
                    result = model_cells[row][col];
                end
            end
            CMD_ADVANCE: begin
                step_generation();
            end
            default: begin
            end
        endcase
        return result;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
        end
    endtask

    // Input driver. The beat on the port is applied to the model in the same edge at
    // which it is taken; a new beat goes out only once the port is free, and then only if
    // the idling roll lets it. Valid is assigned at most once per edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_cell_out.push_back(
                    predict_cell_out(lge_cmd_t'(s_command), s_row, s_column, s_cell_in));
                beats_accepted++;
                if (lge_cmd_t'(s_command) == CMD_ADVANCE) begin
                    advances_done++;
                end
                if (lge_cmd_t'(s_command) == CMD_READ) begin
                    reads_done++;
                end
            end
            if (!s_valid || s_ready) begin
                if (beat_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_beat = beat_queue.pop_front();
                    s_valid   <= 1'b1;
                    s_command <= next_beat.cmd;
                    s_row     <= next_beat.row;
                    s_column  <= next_beat.col;
                    s_cell_in <= next_beat.cell_val;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Counts down the long receiver hold-off once the stimulus asks for one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_seen != hold_request) begin
            hold_seen <= hold_request;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor. Every beat taken on the result channel must match the oldest value
    // still owed; ready is lowered during the long hold-off and at random otherwise.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_cell_out.size() == 0) begin
                    note_mismatch("cell_out with nothing owed", 32'd0, 32'(m_cell_out));
                end else begin
                    if (m_cell_out !== expected_cell_out[0]) begin
                        note_mismatch("cell_out", 32'(expected_cell_out[0]), 32'(m_cell_out));
                    end
                    void'(expected_cell_out.pop_front());
                    results_checked++;
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: a block that stops answering ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                     expected_cell_out.size());
            $display("life_generation_engine regression: fail");
            $finish;
        end
    end

    // Register write: setup cycle, then access cycle; the value lands at the access edge.
    task automatic apb_write(int unsigned index, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(index * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_ROWS) begin
            rows_reg = value[6:0];
        end else if (index == REG_COLS) begin
            cols_reg = value[6:0];
        end
    endtask

    // Register read; the data is sampled at the access edge and must hold the kept 7 bits.
    task automatic apb_read_check(int unsigned index, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 3'(index * 4);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== (value & 32'h7f)) begin
            note_mismatch("size register readback", value & 32'h7f, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sizes are only changed while the block holds no work.
    task automatic set_grid_size(logic [31:0] rows_value, logic [31:0] cols_value);
        apb_write(REG_ROWS, rows_value);
        apb_write(REG_COLS, cols_value);
        apb_read_check(REG_ROWS, rows_value);
        apb_read_check(REG_COLS, cols_value);
        sizes_tried++;
        @(negedge aclk);
    endtask

    task automatic push_beat(lge_cmd_t cmd, int row, int col, bit cell_val);
        life_beat_t b;
        b.cmd      = cmd;
        b.row      = 6'(row);
        b.col      = 6'(col);
        b.cell_val = cell_val;
        beat_queue.push_back(b);
    endtask

    // Blocks until every queued beat has gone out and every result has come back.
    task automatic wait_for_drain();
        do begin
            @(negedge aclk);
        end while (beat_queue.size() != 0 || s_valid || expected_cell_out.size() != 0);
    endtask

    // Random traffic aimed at the active grid: mostly writes that seed live cells, reads
    // of the active cells and advances, with some out-of-grid accesses and unused commands
    // thrown in as noise.
    task automatic queue_mixed_beats(int count, int advance_pct);
        int nr;
        int nc;
        int roll;
        nr = effective_size(rows_reg, GRID_ROWS);
        nc = effective_size(cols_reg, GRID_COLS);
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < advance_pct) begin
                push_beat(CMD_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 1));
            end else if (roll < 45) begin
                push_beat(CMD_WRITE, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                          $urandom_range(0, 99) < 75);
            end else if (roll < 80) begin
                push_beat(CMD_READ, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                          $urandom_range(0, 1));
            end else if (roll < 88) begin
                push_beat(CMD_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 1));
            end else if (roll < 94) begin
                push_beat(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 1));
            end else begin
                push_beat(CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 1));
            end
        end
    endtask

    // A random phase: new sizes and idling, then two bursts with a full pause in between
    // so that the sender waits out every owed result at least once per phase.
    task automatic run_random_phase(int rows_value, int cols_value, int send_pct, int recv_pct,
                                    int advance_pct);
        wait_for_drain();
        set_grid_size(rows_value, cols_value);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_mixed_beats(14, advance_pct);
        wait_for_drain();
        queue_mixed_beats(14, advance_pct);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Full 64 by 64 grid at its reset size. Three live cells in each of two opposite
        // corners make a block, a lone cell in the middle dies, and the corners exercise
        // the all-zero and all-one row and column addresses. The unused command must leave
        // the grid alone and answer 0.
        push_beat(CMD_WRITE, 0, 0, 1'b1);
        push_beat(CMD_WRITE, 0, 1, 1'b1);
        push_beat(CMD_WRITE, 1, 0, 1'b1);
        push_beat(CMD_WRITE, 63, 63, 1'b1);
        push_beat(CMD_WRITE, 63, 62, 1'b1);
        push_beat(CMD_WRITE, 62, 63, 1'b1);
        push_beat(CMD_WRITE, 32, 32, 1'b1);
        push_beat(CMD_READ, 63, 63, 1'b0);
        push_beat(CMD_NONE, 63, 63, 1'b1);
        push_beat(CMD_ADVANCE, 0, 0, 1'b0);
        push_beat(CMD_READ, 1, 1, 1'b0);
        push_beat(CMD_READ, 62, 62, 1'b0);
        push_beat(CMD_READ, 32, 32, 1'b0);
        push_beat(CMD_WRITE, 0, 0, 1'b0);
        push_beat(CMD_READ, 0, 0, 1'b0);

        // Rows written as 0 act as 2, columns written as 127 act as 64. Cells further down
        // are outside the grid: a write there is dropped and a read answers 0, even where
        // the stored cell is live. A cell born on the right edge checks the edge columns.
        wait_for_drain();
        set_grid_size(0, 127);
        push_beat(CMD_WRITE, 5, 5, 1'b1);
        push_beat(CMD_READ, 5, 5, 1'b0);
        push_beat(CMD_READ, 62, 62, 1'b0);
        push_beat(CMD_WRITE, 0, 62, 1'b1);
        push_beat(CMD_WRITE, 1, 62, 1'b1);
        push_beat(CMD_WRITE, 1, 63, 1'b1);
        push_beat(CMD_ADVANCE, 0, 0, 1'b0);
        push_beat(CMD_READ, 0, 63, 1'b0);

        // Rows written as 127 act as 64, columns written as 1 act as 2: a tall thin grid.
        wait_for_drain();
        set_grid_size(127, 1);
        push_beat(CMD_READ, 62, 62, 1'b0);
        push_beat(CMD_ADVANCE, 0, 0, 1'b0);
        push_beat(CMD_READ, 5, 5, 1'b0);

        // Random phases on small grids, one idling pattern each, then the full grid.
        run_random_phase(2, $urandom_range(2, 12), 0, 0, 12);
        run_random_phase($urandom_range(3, 12), $urandom_range(3, 12), 49, 0, 12);
        run_random_phase($urandom_range(3, 12), $urandom_range(3, 12), 0, 49, 12);

        // Long receiver hold-off while the sender keeps offering beats back to back: the
        // output register and the work in flight fill up and the input must stall.
        wait_for_drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request <= hold_request + 1;
        @(negedge aclk);
        queue_mixed_beats(12, 10);

        run_random_phase(64, 64, 13, 13, 5);

        wait_for_drain();
        repeat (20) @(posedge aclk);

        $display("Sent %0d beats (%0d advances, %0d reads) over %0d register settings,",
                 beats_accepted, advances_done, reads_done, sizes_tried + 1);
        $display("checked %0d results under four idling patterns and one long result stall.",
                 results_checked);
        if (mismatch_count == 0 && expected_cell_out.size() == 0) begin
            $display("life_generation_engine regression: pass");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("life_generation_engine regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/lge_pkg.sv
rtl/core/life_generation_engine.sv
rtl/core/lge_checker.sv
tb/tb_life_generation_engine.sv
